// File: rtl/spt_pkg.sv
`timescale 1ns / 1ps
package spt_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 32;

  localparam int IDX_W      = 4;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 20;
  localparam int VC_W       = 5;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [VC_W-1:0]   VC_RESET = VC_W'(16);

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic add;
    logic clear;
    logic init;
    logic scan_rd;
    logic pick;
    logic edge_chk;
    logic edge_upd;
    logic out_rd;
    logic out_ld;
    logic out_next;
  } dp_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic scan_last;
    logic found;
    logic edge_empty;
    logic edge_last;
    logic out_last;
    logic out_taken;
  } dp_stat_t;

endpackage

// File: rtl/spt_ram.sv
`timescale 1ns / 1ps
module spt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/spt_ctrl.sv
`timescale 1ns / 1ps
module spt_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [spt_pkg::OP_W-1:0]  op_i,
  input  spt_pkg::dp_stat_t         stat_i,
  output spt_pkg::dp_cmd_t          cmd_o
);
  import spt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_SCAN_END = 4'd2;
  localparam logic [3:0] S_PICK     = 4'd3;
  localparam logic [3:0] S_EDGE_RD  = 4'd4;
  localparam logic [3:0] S_EDGE_CHK = 4'd5;
  localparam logic [3:0] S_EDGE_UPD = 4'd6;
  localparam logic [3:0] S_OUT_RD   = 4'd7;
  localparam logic [3:0] S_OUT_LD   = 4'd8;
  localparam logic [3:0] S_OUT_HOLD = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_i)
            OP_ADD:   cmd_o.add = 1'b1;
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_SOLVE: begin
              cmd_o.init = 1'b1;
              state_d    = stat_i.start_ok ? S_SCAN : S_OUT_RD;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: state_d = S_PICK;
      S_PICK: begin
        cmd_o.pick = 1'b1;
        if (!stat_i.found) begin
          state_d = S_OUT_RD;
        end else if (stat_i.edge_empty) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_EDGE_RD;
        end
      end
      S_EDGE_RD: state_d = S_EDGE_CHK;
      S_EDGE_CHK: begin
        cmd_o.edge_chk = 1'b1;
        state_d        = S_EDGE_UPD;
      end
      S_EDGE_UPD: begin
        // next edge read overlaps this update
        cmd_o.edge_upd = 1'b1;
        state_d        = stat_i.edge_last ? S_SCAN : S_EDGE_CHK;
      end
      S_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd_o.out_ld = 1'b1;
        state_d      = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (stat_i.out_taken) begin
          cmd_o.out_next = 1'b1;
          state_d        = stat_i.out_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDGE_UPD && stat_i.edge_last) |=> (state_q == S_SCAN))
    else $error("edge pass did not return to the vertex scan");

endmodule

// File: rtl/spt_dp.sv
`timescale 1ns / 1ps
module spt_dp #(
  parameter int MAX_VERTICES = spt_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = spt_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spt_pkg::VC_W-1:0]      cfg_wdata_i,
  input  logic [spt_pkg::IDX_W-1:0]     end_a_i,
  input  logic [spt_pkg::IDX_W-1:0]     end_b_i,
  input  logic [spt_pkg::WEIGHT_W-1:0]  edge_weight_i,
  input  logic [spt_pkg::IDX_W-1:0]     start_vertex_i,
  input  spt_pkg::dp_cmd_t              cmd_i,
  output spt_pkg::dp_stat_t             stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spt_pkg::IDX_W-1:0]     vertex_index_o,
  output logic [spt_pkg::DIST_W-1:0]    distance_o,
  output logic                          reachable_o,
  output logic [spt_pkg::IDX_W-1:0]     parent_vertex_o,
  output logic                          has_parent_o,
  output logic                          edges_dropped_o,
  output logic                          last_o
);
  import spt_pkg::*;

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int XW  = (NW > IDX_W) ? NW : IDX_W;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = WEIGHT_W + 2 * IDX_W;
  localparam int DW  = DIST_W + VAW;

  // configuration and edge table bookkeeping
  logic [VC_W-1:0] vc_q;
  logic [ECW-1:0]  ecnt_q;
  logic            dropped_q;

  // per-solve vertex flags
  logic [MAX_VERTICES-1:0] dvalid_q, pvalid_q, visited_q;

  // sequencing counters
  logic [VAW-1:0] i_q, vo_q;
  logic [EAW-1:0] e_q;

  // scan compare stage and current best
  logic              cmp_vld_q;
  logic [VAW-1:0]    cmp_idx_q;
  logic              found_q;
  logic [VAW-1:0]    best_q;
  logic [DIST_W-1:0] best_d_q;

  // relax stage
  logic                hit_q;
  logic [VAW-1:0]      rv_q;
  logic [WEIGHT_W-1:0] rw_q;

  // output register
  logic              out_valid_q;
  logic [IDX_W-1:0]  vi_q;
  logic [DIST_W-1:0] dist_out_q;
  logic              reach_q;
  logic [IDX_W-1:0]  par_q;
  logic              hasp_q;
  logic              drop_out_q;
  logic              last_q;

  logic [NW-1:0]     n_w;
  logic              start_ok_w;
  logic [VAW-1:0]    start_idx_w;
  logic              table_full_w;
  logic [EW-1:0]     erd_w;
  logic [IDX_W-1:0]  ea_w, eb_w;
  logic              in_range_w, hit_w;
  logic [VAW-1:0]    vsel_w;
  logic              dwe_w;
  logic [VAW-1:0]    dwaddr_w, draddr_w;
  logic [DW-1:0]     dwdata_w, drd_w;
  logic [DIST_W-1:0] cur_d_w;
  logic [VAW-1:0]    cur_p_w;
  logic [DIST_W:0]   sum_w;
  logic [DIST_W-1:0] nd_w;
  logic              take_w, cand_w, out_last_w;

  always_comb begin
    if (vc_q == '0) begin
      n_w = NW'(1);
    end else if (int'(vc_q) > MAX_VERTICES) begin
      n_w = NW'(MAX_VERTICES);
    end else begin
      n_w = NW'(vc_q);
    end
  end

  assign start_ok_w   = XW'(start_vertex_i) < XW'(n_w);
  assign start_idx_w  = VAW'(start_vertex_i);
  assign table_full_w = (ecnt_q == ECW'(MAX_EDGES));

  spt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add && !table_full_w),
    .waddr_i (ecnt_q[EAW-1:0]),
    .wdata_i ({edge_weight_i, end_b_i, end_a_i}),
    .raddr_i (cmd_i.edge_upd ? (e_q + EAW'(1)) : e_q),
    .rdata_o (erd_w)
  );

  assign ea_w       = erd_w[IDX_W-1:0];
  assign eb_w       = erd_w[2*IDX_W-1:IDX_W];
  assign in_range_w = (XW'(ea_w) < XW'(n_w)) && (XW'(eb_w) < XW'(n_w));

  // pick the far end of an edge that touches the vertex just visited
  always_comb begin
    hit_w  = 1'b0;
    vsel_w = VAW'(eb_w);
    if (in_range_w) begin
      if (VAW'(ea_w) == best_q) begin
        hit_w  = 1'b1;
        vsel_w = VAW'(eb_w);
      end else if (VAW'(eb_w) == best_q) begin
        hit_w  = 1'b1;
        vsel_w = VAW'(ea_w);
      end
    end
  end

  assign cur_d_w = drd_w[DIST_W-1:0];
  assign cur_p_w = drd_w[DW-1:DIST_W];
  assign sum_w   = {1'b0, best_d_q} + (DIST_W + 1)'(rw_q);
  assign nd_w    = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];

  assign take_w = cmd_i.edge_upd && hit_q && !visited_q[rv_q] &&
                  (!dvalid_q[rv_q] || (nd_w < cur_d_w) ||
                   ((nd_w == cur_d_w) && pvalid_q[rv_q] && (best_q < cur_p_w)));

  assign cand_w = cmp_vld_q && dvalid_q[cmp_idx_q] && !visited_q[cmp_idx_q] &&
                  (!found_q || (cur_d_w < best_d_q));

  assign dwe_w    = (cmd_i.init && start_ok_w) || take_w;
  assign dwaddr_w = cmd_i.init ? start_idx_w : rv_q;
  assign dwdata_w = cmd_i.init ? {VAW'(0), DIST_W'(0)} : {best_q, nd_w};
  assign draddr_w = cmd_i.edge_chk ? vsel_w : (cmd_i.out_rd ? vo_q : i_q);

  spt_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dwe_w),
    .waddr_i (dwaddr_w),
    .wdata_i (dwdata_w),
    .raddr_i (draddr_w),
    .rdata_o (drd_w)
  );

  assign out_last_w = (NW'(vo_q) == (n_w - NW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= VC_RESET;
      ecnt_q      <= '0;
      dropped_q   <= 1'b0;
      dvalid_q    <= '0;
      pvalid_q    <= '0;
      visited_q   <= '0;
      i_q         <= '0;
      vo_q        <= '0;
      e_q         <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      if (cmd_i.add) begin
        if (table_full_w) begin
          dropped_q <= 1'b1;
        end else begin
          ecnt_q <= ecnt_q + ECW'(1);
        end
      end
      if (cmd_i.clear) begin
        ecnt_q    <= '0;
        dropped_q <= 1'b0;
      end
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        i_q <= i_q + VAW'(1);
      end
      if (cand_w) begin
        found_q <= 1'b1;
      end
      if (cmd_i.init) begin
        dvalid_q  <= start_ok_w ? (MAX_VERTICES'(1) << start_idx_w) : '0;
        pvalid_q  <= '0;
        visited_q <= '0;
        i_q       <= '0;
        vo_q      <= '0;
        found_q   <= 1'b0;
      end
      if (cmd_i.pick) begin
        if (found_q) begin
          visited_q[best_q] <= 1'b1;
        end
        i_q     <= '0;
        vo_q    <= '0;
        e_q     <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.edge_upd) begin
        e_q <= e_q + EAW'(1);
      end
      if (take_w) begin
        dvalid_q[rv_q] <= 1'b1;
        pvalid_q[rv_q] <= 1'b1;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.out_next) begin
        vo_q <= vo_q + VAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      cmp_idx_q <= i_q;
    end
    if (cand_w) begin
      best_q   <= cmp_idx_q;
      best_d_q <= cur_d_w;
    end
    if (cmd_i.edge_chk) begin
      hit_q <= hit_w;
      rv_q  <= vsel_w;
      rw_q  <= erd_w[EW-1:2*IDX_W];
    end
    if (cmd_i.out_ld) begin
      vi_q       <= IDX_W'(vo_q);
      dist_out_q <= dvalid_q[vo_q] ? cur_d_w : '0;
      reach_q    <= dvalid_q[vo_q];
      par_q      <= pvalid_q[vo_q] ? IDX_W'(cur_p_w) : '0;
      hasp_q     <= pvalid_q[vo_q];
      drop_out_q <= dropped_q;
      last_q     <= out_last_w;
    end
  end

  assign stat_o.start_ok   = start_ok_w;
  assign stat_o.scan_last  = (NW'(i_q) == (n_w - NW'(1)));
  assign stat_o.found      = found_q;
  assign stat_o.edge_empty = (ecnt_q == '0);
  assign stat_o.edge_last  = (ECW'(e_q) == (ecnt_q - ECW'(1)));
  assign stat_o.out_last   = out_last_w;
  assign stat_o.out_taken  = out_valid_q && out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign vertex_index_o  = vi_q;
  assign distance_o      = dist_out_q;
  assign reachable_o     = reach_q;
  assign parent_vertex_o = par_q;
  assign has_parent_o    = hasp_q;
  assign edges_dropped_o = drop_out_q;
  assign last_o          = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (visited_q & ~dvalid_q) == '0)
    else $error("visited vertex without a distance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pvalid_q & ~dvalid_q) == '0)
    else $error("parent set on a vertex without a distance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pick && found_q) |=> visited_q[$past(best_q)])
    else $error("picked vertex not marked visited");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_w |=> (dvalid_q[$past(rv_q)] && pvalid_q[$past(rv_q)]))
    else $error("relaxed vertex lost its distance or parent");

endmodule

// File: rtl/shortest_path_tree_solver_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tuser: op; tdata: end_a, end_b, edge_weight,
//                                            start_vertex
// m_axis    out  m_axis_tvalid/tready        tdata: vertex_index, distance, reachable,
//                                            parent_vertex, has_parent, edges_dropped; tlast
// cfg       in   cfg_we_i                    cfg_wdata_i: vertex_count
//
// A solve of n vertices and E stored edges runs up to n + 1 rounds (vertex scan, one dist
// RAM read per vertex, then pick); a round that visits a vertex with E > 0 adds an edge pass
// (edge RAM read overlapped with the dist RAM read-modify-write), then one result row per
// vertex is sent on m_axis, each row held until it is taken.
// rst_ni clears the edge count, dropped flag and vertex flags; vertex_count resets to 16.
// s_axis_tready is low from a solve's acceptance until its last row is taken.
module shortest_path_tree_solver_top #(
  parameter int MAX_VERTICES = spt_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = spt_pkg::MAX_EDGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spt_pkg::VC_W-1:0]          cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // end_a[3:0], end_b[7:4], edge_weight[23:8], start_vertex[27:24], zero fill
  input  logic [spt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // op[1:0]
  input  logic [spt_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // vertex_index[3:0], distance[23:4], reachable[24], parent_vertex[28:25],
  // has_parent[29], edges_dropped[30], zero fill
  output logic [spt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);
  import spt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [IDX_W-1:0]  vertex_index;
  logic [DIST_W-1:0] distance;
  logic              reachable;
  logic [IDX_W-1:0]  parent_vertex;
  logic              has_parent;
  logic              edges_dropped;

  spt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spt_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .end_a_i         (s_axis_tdata[3:0]),
    .end_b_i         (s_axis_tdata[7:4]),
    .edge_weight_i   (s_axis_tdata[23:8]),
    .start_vertex_i  (s_axis_tdata[27:24]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .vertex_index_o  (vertex_index),
    .distance_o      (distance),
    .reachable_o     (reachable),
    .parent_vertex_o (parent_vertex),
    .has_parent_o    (has_parent),
    .edges_dropped_o (edges_dropped),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, edges_dropped, has_parent, parent_vertex, reachable,
                         distance, vertex_index};

endmodule
